// ===== sv/dbe_pkg.sv =====
// Package for the deque/bag engine: sizes, operation and status codes, and the
// structs passed between the sequencer, the memories and the top level.
// No dependencies.
package dbe_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } val_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [VAL_W-1:0]  front_value;
    logic [VAL_W-1:0]  back_value;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
  } result_t;

endpackage

// ===== sv/dbe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dbe_next_ram.sv =====
// Forward-link memory. Entries never written since reset read as the free-list
// chain (slot i points to i+1, the last slot to 0). Depends on dbe_pkg.
module dbe_next_ram import dbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  link_wr_t          wr,
  input  logic [SLOT_W-1:0] raddr,
  output logic [SLOT_W-1:0] rdata
);

  logic [SLOT_W-1:0]   mem [CAPACITY];
  logic [CAPACITY-1:0] written;
  logic [SLOT_W-1:0]   mem_q;
  logic [SLOT_W-1:0]   raddr_q;
  logic                rd_written;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q   <= mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      rd_written <= written[raddr];
      if (wr.we) begin
        written[wr.addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (rd_written) begin
      rdata = mem_q;
    end else if (raddr_q == SLOT_W'(CAPACITY - 1)) begin
      rdata = '0;
    end else begin
      rdata = raddr_q + SLOT_W'(1);
    end
  end

endmodule

// ===== sv/dbe_seq.sv =====
// Sequencer of the deque/bag engine: head, tail, free-list and count registers,
// the per-operation state machine and the memory request generation.
// Depends on dbe_pkg.
module dbe_seq import dbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [VAL_W-1:0]  item_value,
  output logic [SLOT_W-1:0] rd_addr,
  output val_wr_t           vwr,
  output link_wr_t          nwr,
  output link_wr_t          pwr,
  input  logic [VAL_W-1:0]  vdata,
  input  logic [SLOT_W-1:0] ndata,
  input  logic [SLOT_W-1:0] pdata,
  input  logic              out_free,
  output logic              res_valid,
  output result_t           res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_UNLINK = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FVAL   = 3'd4;
  localparam logic [2:0] S_BVAL   = 3'd5;
  localparam logic [2:0] S_FREE   = 3'd6;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] first_slot, first_slot_next;
  logic [SLOT_W-1:0] last_slot, last_slot_next;
  logic [SLOT_W-1:0] free_head, free_head_next;
  logic [CNT_W-1:0]  held_count, held_count_next;
  logic [VAL_W-1:0]  front_val, front_val_next;
  logic [VAL_W-1:0]  back_val, back_val_next;
  logic [MODE_W-1:0] op_mode, op_mode_next;
  logic [VAL_W-1:0]  op_val, op_val_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;
  logic [CNT_W-1:0]  walk_cnt, walk_cnt_next;
  logic              pend, pend_next;
  logic [STAT_W-1:0] pend_status, pend_status_next;
  logic              pend_found, pend_found_next;
  logic              out_load;
  logic              hit;
  logic              do_unlink;

  assign out_load  = pend && out_free;
  assign req_stall = (state != S_IDLE) || (pend && !out_free);
  assign hit       = (vdata == op_val);

  always_comb begin
    state_next       = state;
    first_slot_next  = first_slot;
    last_slot_next   = last_slot;
    free_head_next   = free_head;
    held_count_next  = held_count;
    front_val_next   = front_val;
    back_val_next    = back_val;
    op_mode_next     = op_mode;
    op_val_next      = op_val;
    cur_slot_next    = cur_slot;
    walk_cnt_next    = walk_cnt;
    pend_next        = pend && !out_load;
    pend_status_next = pend_status;
    pend_found_next  = pend_found;
    rd_addr          = cur_slot;
    vwr              = '0;
    nwr              = '0;
    pwr              = '0;
    do_unlink        = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          op_mode_next = mode;
          op_val_next  = item_value;
          case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (held_count == CNT_W'(CAPACITY)) begin
                pend_next        = 1'b1;
                pend_status_next = STAT_FULL;
                pend_found_next  = 1'b0;
              end else begin
                rd_addr    = free_head;
                state_next = S_PUSH;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (held_count == '0) begin
                pend_next        = 1'b1;
                pend_status_next = STAT_EMPTY;
                pend_found_next  = 1'b0;
              end else begin
                rd_addr       = (mode == MODE_POP_FRONT) ? first_slot : last_slot;
                cur_slot_next = rd_addr;
                state_next    = S_UNLINK;
              end
            end
            MODE_CONTAINS, MODE_REMOVE: begin
              if (held_count == '0) begin
                pend_next        = 1'b1;
                pend_status_next = STAT_OK;
                pend_found_next  = 1'b0;
              end else begin
                rd_addr       = first_slot;
                cur_slot_next = first_slot;
                walk_cnt_next = CNT_W'(1);
                state_next    = S_WALK;
              end
            end
            default: begin
              pend_next        = 1'b1;
              pend_status_next = STAT_OK;
              pend_found_next  = 1'b0;
            end
          endcase
        end
      end
      S_PUSH: begin
        // The link read of the free head is back; the slot is taken now.
        free_head_next = ndata;
        vwr            = '{we: 1'b1, addr: free_head, data: op_val};
        if (held_count == '0) begin
          first_slot_next = free_head;
          last_slot_next  = free_head;
          front_val_next  = op_val;
          back_val_next   = op_val;
        end else if (op_mode == MODE_PUSH_FRONT) begin
          nwr             = '{we: 1'b1, addr: free_head, data: first_slot};
          pwr             = '{we: 1'b1, addr: first_slot, data: free_head};
          first_slot_next = free_head;
          front_val_next  = op_val;
        end else begin
          pwr            = '{we: 1'b1, addr: free_head, data: last_slot};
          nwr            = '{we: 1'b1, addr: last_slot, data: free_head};
          last_slot_next = free_head;
          back_val_next  = op_val;
        end
        held_count_next  = held_count + CNT_W'(1);
        pend_next        = 1'b1;
        pend_status_next = STAT_OK;
        pend_found_next  = 1'b0;
        state_next       = S_IDLE;
      end
      S_WALK: begin
        if (hit) begin
          if (op_mode == MODE_REMOVE) begin
            do_unlink = 1'b1;
          end else begin
            pend_next        = 1'b1;
            pend_status_next = STAT_OK;
            pend_found_next  = 1'b1;
            state_next       = S_IDLE;
          end
        end else if (walk_cnt == held_count) begin
          pend_next        = 1'b1;
          pend_status_next = STAT_OK;
          pend_found_next  = 1'b0;
          state_next       = S_IDLE;
        end else begin
          rd_addr       = ndata;
          cur_slot_next = ndata;
          walk_cnt_next = walk_cnt + CNT_W'(1);
        end
      end
      S_UNLINK: begin
        do_unlink = 1'b1;
      end
      S_FVAL: begin
        front_val_next   = vdata;
        pend_next        = 1'b1;
        pend_status_next = STAT_OK;
        pend_found_next  = (op_mode == MODE_REMOVE);
        state_next       = S_IDLE;
      end
      S_BVAL: begin
        back_val_next    = vdata;
        pend_next        = 1'b1;
        pend_status_next = STAT_OK;
        pend_found_next  = (op_mode == MODE_REMOVE);
        state_next       = S_IDLE;
      end
      S_FREE: begin
        nwr              = '{we: 1'b1, addr: cur_slot, data: free_head};
        free_head_next   = cur_slot;
        held_count_next  = held_count - CNT_W'(1);
        pend_next        = 1'b1;
        pend_status_next = STAT_OK;
        pend_found_next  = (op_mode == MODE_REMOVE);
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Unlink of cur_slot; its forward and backward links are on the read data.
    if (do_unlink) begin
      if (held_count <= CNT_W'(1)) begin
        first_slot_next  = '0;
        last_slot_next   = '0;
        nwr              = '{we: 1'b1, addr: cur_slot, data: free_head};
        free_head_next   = cur_slot;
        held_count_next  = held_count - CNT_W'(1);
        pend_next        = 1'b1;
        pend_status_next = STAT_OK;
        pend_found_next  = (op_mode == MODE_REMOVE);
        state_next       = S_IDLE;
      end else if (cur_slot == first_slot) begin
        first_slot_next = ndata;
        nwr             = '{we: 1'b1, addr: cur_slot, data: free_head};
        free_head_next  = cur_slot;
        held_count_next = held_count - CNT_W'(1);
        rd_addr         = ndata;
        state_next      = S_FVAL;
      end else if (cur_slot == last_slot) begin
        last_slot_next  = pdata;
        nwr             = '{we: 1'b1, addr: cur_slot, data: free_head};
        free_head_next  = cur_slot;
        held_count_next = held_count - CNT_W'(1);
        rd_addr         = pdata;
        state_next      = S_BVAL;
      end else begin
        nwr        = '{we: 1'b1, addr: pdata, data: ndata};
        pwr        = '{we: 1'b1, addr: ndata, data: pdata};
        state_next = S_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_slot <= '0;
      last_slot  <= '0;
      free_head  <= '0;
      held_count <= '0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      first_slot <= first_slot_next;
      last_slot  <= last_slot_next;
      free_head  <= free_head_next;
      held_count <= held_count_next;
      pend       <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    front_val   <= front_val_next;
    back_val    <= back_val_next;
    op_mode     <= op_mode_next;
    op_val      <= op_val_next;
    cur_slot    <= cur_slot_next;
    walk_cnt    <= walk_cnt_next;
    pend_status <= pend_status_next;
    pend_found  <= pend_found_next;
  end

  assign res_valid = pend;

  always_comb begin
    res.status      = pend_status;
    res.found       = pend_found;
    res.entry_count = held_count;
    res.is_empty    = (held_count == '0);
    res.front_value = (held_count == '0) ? '0 : front_val;
    res.back_value  = (held_count == '0) ? '0 : back_val;
  end

endmodule

// ===== sv/deque_bag_engine.sv =====
// Top level of the deque/bag engine: memories, sequencer and result register.
// Depends on dbe_pkg, dbe_ram, dbe_next_ram and dbe_seq.
//
// This block is a bounded double-ended queue of CAPACITY 32-bit entries that
// also serves as a bag. Each request transaction carries a mode (push front,
// push back, pop front, pop back, contains, remove first match) and a value,
// and yields exactly one result transaction with a status, a found flag, the
// front and back values, the entry count and an empty flag, all describing
// the store after the request. Requests are processed one at a time. A push
// reads the free-list head's link on acceptance, then completes in the push
// state. A pop unlinks its entry in the unlink state, then reads the new end
// value in the front-value or back-value state, or ends on unlinking when it
// empties the store. Contains and remove search the forward links one entry
// per cycle until a match or the end of the list; a matching remove then
// unlinks the entry and passes through the front-value, back-value or free
// state, unless it was the only entry, which completes with the search.
// Rejected pushes and pops, searches of an empty store and unused modes
// complete in the cycle of acceptance. These steps come from the one read
// port of each link memory: every link step waits for its registered read
// data. A result waits in a pending register until the output register is
// free; a new request can be taken in the cycle it is loaded there, and while
// it stays stalled. Entries live in slots of three memories (values, forward
// links, backward links); unused slots form a free list held in the forward
// links. The forward-link memory carries one valid flag per slot so it reads
// as the initial free-list chain after reset without any clearing pass.
module deque_bag_engine import dbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [VAL_W-1:0]  item_value,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [STAT_W-1:0] status,
  output logic              found,
  output logic [VAL_W-1:0]  front_value,
  output logic [VAL_W-1:0]  back_value,
  output logic [CNT_W-1:0]  entry_count,
  output logic              is_empty
);

  logic [SLOT_W-1:0] rd_addr;
  val_wr_t           vwr;
  link_wr_t          nwr;
  link_wr_t          pwr;
  logic [VAL_W-1:0]  vdata;
  logic [SLOT_W-1:0] ndata;
  logic [SLOT_W-1:0] pdata;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  logic              out_load;

  // The output register is free when empty or when its transaction completes.
  assign out_free = !rsp_valid || !rsp_stall;
  assign out_load = res_valid && out_free;

  dbe_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (vwr.we),
    .waddr (vwr.addr),
    .wdata (vwr.data),
    .raddr (rd_addr),
    .rdata (vdata)
  );

  dbe_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pwr.we),
    .waddr (pwr.addr),
    .wdata (pwr.data),
    .raddr (rd_addr),
    .rdata (pdata)
  );

  dbe_next_ram u_next_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (nwr),
    .raddr (rd_addr),
    .rdata (ndata)
  );

  dbe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .item_value (item_value),
    .rd_addr    (rd_addr),
    .vwr        (vwr),
    .nwr        (nwr),
    .pwr        (pwr),
    .vdata      (vdata),
    .ndata      (ndata),
    .pdata      (pdata),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: holds its transaction steady while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res.status;
      found       <= res.found;
      front_value <= res.front_value;
      back_value  <= res.back_value;
      entry_count <= res.entry_count;
      is_empty    <= res.is_empty;
    end
  end

endmodule
